@@ rtl/elcsr_pkg.sv @@
// Shared constants and codes for the edge list to CSR builder.
package elcsr_pkg;

    localparam int OP_W      = 2;
    localparam int VID_W     = 10;
    localparam int IDX_W     = 13;
    localparam int STATUS_W  = 2;
    localparam int VALUE_W   = 13;
    localparam int VCNT_W    = 11;
    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;

    localparam int MAX_VERTICES_DEF = 1024;
    localparam int MAX_EDGES_DEF    = 4096;

    localparam logic [VCNT_W-1:0] NUM_VERTICES_RST = 11'd1024;

    // register index, taken from paddr bit 2
    localparam logic REG_NUM_VERTICES = 1'b0;

    localparam logic [OP_W-1:0] OP_LOAD     = 2'd0;
    localparam logic [OP_W-1:0] OP_BUILD    = 2'd1;
    localparam logic [OP_W-1:0] OP_READ_OFF = 2'd2;
    localparam logic [OP_W-1:0] OP_READ_NBR = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_VERTEX = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL       = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_READ   = 2'd3;

endpackage

@@ rtl/elcsr_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module elcsr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ rtl/edge_list_to_csr_builder_unit.sv @@
// Top level of the edge list to CSR builder: sequencer, counters and memories.
//
// Converts loaded directed edges to compressed sparse row form. One item is
// worked at a time and one result transfer follows each. A load writes the
// edge RAMs, then the raised degree; a build runs a prefix sum that reads
// each of the MAX_VERTICES degrees and then writes its offset, then a scatter
// that reads each loaded edge, then its row's degree and offset, then writes
// the neighbour, all limited by the single read port of each RAM. After reset
// a clearing pass over all MAX_VERTICES entries zeroes the degree RAM; no item
// is taken during it, while register writes are. A finished result waits in an
// output register, so the next item can be taken before it is collected.
module edge_list_to_csr_builder_unit #(
    parameter int MAX_VERTICES = elcsr_pkg::MAX_VERTICES_DEF,
    parameter int MAX_EDGES    = elcsr_pkg::MAX_EDGES_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [elcsr_pkg::OP_W-1:0]     operation,
    input  logic [elcsr_pkg::VID_W-1:0]    src_vertex,
    input  logic [elcsr_pkg::VID_W-1:0]    dst_vertex,
    input  logic [elcsr_pkg::IDX_W-1:0]    read_index,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [elcsr_pkg::STATUS_W-1:0] status,
    output logic [elcsr_pkg::VALUE_W-1:0]  read_value,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [elcsr_pkg::APB_AW-1:0]   paddr,
    input  logic [elcsr_pkg::APB_DW-1:0]   pwdata,
    output logic [elcsr_pkg::APB_DW-1:0]   prdata,
    output logic                           pready
);

    import elcsr_pkg::*;

    localparam int VIDW = $clog2(MAX_VERTICES);
    localparam int NW   = $clog2(MAX_VERTICES + 1);
    localparam int OAW  = $clog2(MAX_VERTICES + 1);
    localparam int EW   = $clog2(MAX_EDGES + 1);
    localparam int EAW  = $clog2(MAX_EDGES);
    localparam int CW0  = (IDX_W > VCNT_W) ? IDX_W : VCNT_W;
    localparam int CW1  = (CW0 > NW) ? CW0 : NW;
    localparam int CW2  = (CW1 > EW) ? CW1 : EW;
    localparam int CW   = (CW2 > VID_W) ? CW2 : VID_W;

    localparam logic [3:0] S_CLEAR     = 4'd0;
    localparam logic [3:0] S_IDLE      = 4'd1;
    localparam logic [3:0] S_LOAD_WR   = 4'd2;
    localparam logic [3:0] S_READ_WAIT = 4'd3;
    localparam logic [3:0] S_PFX_RD    = 4'd4;
    localparam logic [3:0] S_PFX_WR    = 4'd5;
    localparam logic [3:0] S_SCAT_RD0  = 4'd6;
    localparam logic [3:0] S_SCAT_RD1  = 4'd7;
    localparam logic [3:0] S_SCAT_WR   = 4'd8;
    localparam logic [3:0] S_BUILD_END = 4'd9;
    localparam logic [3:0] S_FIN       = 4'd10;

    // control state
    logic [3:0]        state_reg, state_next;
    logic [VCNT_W-1:0] num_vertices_reg;
    logic [EW-1:0]     loaded_reg, loaded_next;
    logic [EW-1:0]     built_reg, built_next;
    logic              rows_valid_reg, rows_valid_next;
    logic [VIDW-1:0]   vcnt_reg, vcnt_next;
    logic              out_valid_reg, out_valid_next;

    // payload
    logic [EW-1:0]       ecnt_reg, ecnt_next;
    logic [EW-1:0]       acc_reg, acc_next;
    logic [VIDW-1:0]     u_reg, u_next;
    logic [VIDW-1:0]     t_reg, t_next;
    logic [VIDW-1:0]     ld_src_reg, ld_src_next;
    logic [OP_W-1:0]     op_reg, op_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [VALUE_W-1:0]  res_value_reg, res_value_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [VALUE_W-1:0]  read_value_reg, read_value_next;

    // memory ports
    logic            deg_we, deg_re;
    logic [VIDW-1:0] deg_waddr, deg_raddr;
    logic [EW-1:0]   deg_wdata, deg_rdata;
    logic            off_we, off_re;
    logic [OAW-1:0]  off_waddr, off_raddr;
    logic [EW-1:0]   off_wdata, off_rdata;
    logic            edge_we, edge_re;
    logic [EAW-1:0]  edge_waddr, edge_raddr;
    logic [VIDW-1:0] src_rdata, dst_rdata;
    logic            nbr_we, nbr_re;
    logic [EAW-1:0]  nbr_waddr, nbr_raddr;
    logic [VIDW-1:0] nbr_rdata;

    logic [NW-1:0] nv;
    logic          accept;
    logic          out_xfer;
    logic          cfg_wr;
    logic          bad_vertex;
    logic          store_full;
    logic          off_bad;
    logic          nbr_bad;
    logic [EW-1:0] slot;

    assign accept   = in_valid && !in_stall;
    assign out_xfer = out_valid_reg && !out_stall;
    assign in_stall = (state_reg != S_IDLE);
    assign cfg_wr   = psel && penable && pwrite && pready && (paddr[2] == REG_NUM_VERTICES);
    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == REG_NUM_VERTICES) ? APB_DW'(num_vertices_reg) : '0;

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign read_value = read_value_reg;

    assign nv = (CW'(num_vertices_reg) > CW'(MAX_VERTICES)) ? NW'(MAX_VERTICES)
                                                           : NW'(num_vertices_reg);

    assign bad_vertex = (CW'(src_vertex) >= CW'(nv)) || (CW'(dst_vertex) >= CW'(nv));
    assign store_full = (loaded_reg >= EW'(MAX_EDGES));
    assign off_bad    = !rows_valid_reg || (CW'(read_index) > CW'(nv));
    assign nbr_bad    = !rows_valid_reg || (CW'(read_index) >= CW'(built_reg))
                        || (CW'(read_index) >= CW'(MAX_EDGES));
    assign slot       = off_rdata + deg_rdata - EW'(1);

    always_comb
    begin
        state_next      = state_reg;
        loaded_next     = loaded_reg;
        built_next      = built_reg;
        rows_valid_next = rows_valid_reg;
        vcnt_next       = vcnt_reg;
        out_valid_next  = out_valid_reg;
        ecnt_next       = ecnt_reg;
        acc_next        = acc_reg;
        u_next          = u_reg;
        t_next          = t_reg;
        ld_src_next     = ld_src_reg;
        op_next         = op_reg;
        res_status_next = res_status_reg;
        res_value_next  = res_value_reg;
        status_next     = status_reg;
        read_value_next = read_value_reg;

        deg_we     = 1'b0;
        deg_waddr  = vcnt_reg;
        deg_wdata  = '0;
        deg_re     = 1'b0;
        deg_raddr  = vcnt_reg;
        off_we     = 1'b0;
        off_waddr  = '0;
        off_wdata  = '0;
        off_re     = 1'b0;
        off_raddr  = OAW'(read_index);
        edge_we    = 1'b0;
        edge_waddr = loaded_reg[EAW-1:0];
        edge_re    = 1'b0;
        edge_raddr = ecnt_reg[EAW-1:0];
        nbr_we     = 1'b0;
        nbr_waddr  = slot[EAW-1:0];
        nbr_re     = 1'b0;
        nbr_raddr  = EAW'(read_index);

        if (out_xfer)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                deg_we = 1'b1;
                if (vcnt_reg == VIDW'(MAX_VERTICES - 1))
                begin
                    vcnt_next  = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    vcnt_next = vcnt_reg + VIDW'(1);
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next         = operation;
                    res_status_next = ST_OK;
                    res_value_next  = '0;
                    case (operation)
                        OP_LOAD:
                        begin
                            if (bad_vertex)
                            begin
                                res_status_next = ST_BAD_VERTEX;
                                state_next      = S_FIN;
                            end
                            else if (store_full)
                            begin
                                res_status_next = ST_FULL;
                                state_next      = S_FIN;
                            end
                            else
                            begin
                                edge_we     = 1'b1;
                                deg_re      = 1'b1;
                                deg_raddr   = VIDW'(src_vertex);
                                ld_src_next = VIDW'(src_vertex);
                                state_next  = S_LOAD_WR;
                            end
                        end
                        OP_BUILD:
                        begin
                            off_we     = 1'b1;
                            vcnt_next  = '0;
                            acc_next   = '0;
                            state_next = S_PFX_RD;
                        end
                        OP_READ_OFF:
                        begin
                            if (off_bad)
                            begin
                                res_status_next = ST_BAD_READ;
                                state_next      = S_FIN;
                            end
                            else
                            begin
                                off_re     = 1'b1;
                                state_next = S_READ_WAIT;
                            end
                        end
                        default:
                        begin
                            if (nbr_bad)
                            begin
                                res_status_next = ST_BAD_READ;
                                state_next      = S_FIN;
                            end
                            else
                            begin
                                nbr_re     = 1'b1;
                                state_next = S_READ_WAIT;
                            end
                        end
                    endcase
                end
            end
            S_LOAD_WR:
            begin
                deg_we      = 1'b1;
                deg_waddr   = ld_src_reg;
                deg_wdata   = deg_rdata + EW'(1);
                loaded_next = loaded_reg + EW'(1);
                state_next  = S_FIN;
            end
            S_READ_WAIT:
            begin
                res_value_next = (op_reg == OP_READ_OFF) ? VALUE_W'(off_rdata)
                                                         : VALUE_W'(nbr_rdata);
                state_next     = S_FIN;
            end
            S_PFX_RD:
            begin
                deg_re     = 1'b1;
                state_next = S_PFX_WR;
            end
            S_PFX_WR:
            begin
                off_we    = 1'b1;
                off_waddr = OAW'(vcnt_reg) + OAW'(1);
                off_wdata = acc_reg + deg_rdata;
                acc_next  = acc_reg + deg_rdata;
                if (vcnt_reg == VIDW'(MAX_VERTICES - 1))
                begin
                    vcnt_next  = '0;
                    ecnt_next  = '0;
                    state_next = (loaded_reg == '0) ? S_BUILD_END : S_SCAT_RD0;
                end
                else
                begin
                    vcnt_next  = vcnt_reg + VIDW'(1);
                    state_next = S_PFX_RD;
                end
            end
            S_SCAT_RD0:
            begin
                edge_re    = 1'b1;
                state_next = S_SCAT_RD1;
            end
            S_SCAT_RD1:
            begin
                u_next     = src_rdata;
                t_next     = dst_rdata;
                deg_re     = 1'b1;
                deg_raddr  = src_rdata;
                off_re     = 1'b1;
                off_raddr  = OAW'(src_rdata);
                state_next = S_SCAT_WR;
            end
            S_SCAT_WR:
            begin
                // fill the row from its end
                deg_we    = 1'b1;
                deg_waddr = u_reg;
                deg_wdata = deg_rdata - EW'(1);
                nbr_we    = 1'b1;
                if (ecnt_reg + EW'(1) == loaded_reg)
                begin
                    state_next = S_BUILD_END;
                end
                else
                begin
                    ecnt_next  = ecnt_reg + EW'(1);
                    state_next = S_SCAT_RD0;
                end
            end
            S_BUILD_END:
            begin
                built_next      = loaded_reg;
                loaded_next     = '0;
                rows_valid_next = 1'b1;
                state_next      = S_FIN;
            end
            S_FIN:
            begin
                if (!out_valid_reg || out_xfer)
                begin
                    out_valid_next  = 1'b1;
                    status_next     = res_status_reg;
                    read_value_next = res_value_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_CLEAR;
            num_vertices_reg <= NUM_VERTICES_RST;
            loaded_reg       <= '0;
            built_reg        <= '0;
            rows_valid_reg   <= 1'b0;
            vcnt_reg         <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            loaded_reg     <= loaded_next;
            built_reg      <= built_next;
            rows_valid_reg <= rows_valid_next;
            vcnt_reg       <= vcnt_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_wr)
            begin
                num_vertices_reg <= pwdata[VCNT_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ecnt_reg       <= ecnt_next;
        acc_reg        <= acc_next;
        u_reg          <= u_next;
        t_reg          <= t_next;
        ld_src_reg     <= ld_src_next;
        op_reg         <= op_next;
        res_status_reg <= res_status_next;
        res_value_reg  <= res_value_next;
        status_reg     <= status_next;
        read_value_reg <= read_value_next;
    end

    elcsr_ram #(.WIDTH(EW), .DEPTH(MAX_VERTICES)) u_deg_ram (
        .clk   (clk),
        .we    (deg_we),
        .waddr (deg_waddr),
        .wdata (deg_wdata),
        .re    (deg_re),
        .raddr (deg_raddr),
        .rdata (deg_rdata)
    );

    elcsr_ram #(.WIDTH(EW), .DEPTH(MAX_VERTICES + 1)) u_off_ram (
        .clk   (clk),
        .we    (off_we),
        .waddr (off_waddr),
        .wdata (off_wdata),
        .re    (off_re),
        .raddr (off_raddr),
        .rdata (off_rdata)
    );

    elcsr_ram #(.WIDTH(VIDW), .DEPTH(MAX_EDGES)) u_src_ram (
        .clk   (clk),
        .we    (edge_we),
        .waddr (edge_waddr),
        .wdata (VIDW'(src_vertex)),
        .re    (edge_re),
        .raddr (edge_raddr),
        .rdata (src_rdata)
    );

    elcsr_ram #(.WIDTH(VIDW), .DEPTH(MAX_EDGES)) u_dst_ram (
        .clk   (clk),
        .we    (edge_we),
        .waddr (edge_waddr),
        .wdata (VIDW'(dst_vertex)),
        .re    (edge_re),
        .raddr (edge_raddr),
        .rdata (dst_rdata)
    );

    elcsr_ram #(.WIDTH(VIDW), .DEPTH(MAX_EDGES)) u_nbr_ram (
        .clk   (clk),
        .we    (nbr_we),
        .waddr (nbr_waddr),
        .wdata (t_reg),
        .re    (nbr_re),
        .raddr (nbr_raddr),
        .rdata (nbr_rdata)
    );

    a_loaded_bound: assert property (@(posedge clk) disable iff (!rst_n)
        loaded_reg <= EW'(MAX_EDGES))
        else $error("edge count above store depth");

    a_prefix_total: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_BUILD_END) |-> (acc_reg == loaded_reg))
        else $error("prefix sum total differs from loaded edges");

    a_scatter_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAT_WR) |-> (deg_rdata != '0))
        else $error("scatter found an empty row position");

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("second transfer taken while an item is in work");

endmodule
